// ===== design/qrs_pkg.sv =====
package qrs_pkg;

   localparam int ROOT_WIDTH = 34;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      CLS_INFINITE = 3'd0,
      CLS_NONE     = 3'd1,
      CLS_NO_REAL  = 3'd2,
      CLS_ONE      = 3'd3,
      CLS_TWO      = 3'd4
   } qrs_class_type;

endpackage

// ===== design/quadratic_root_solver.sv =====
// Throughput: one word per cycle while rsp_stall is low; the sqrt stages
// (one root bit each) and the long-division stages (one quotient bit each) are fully pipelined.
// A 4-deep queue between front and back lets each side stall on its own.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
module quadratic_root_solver import qrs_pkg::*; #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_a,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_b,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_c,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_solution_class,
   output logic signed [ROOT_WIDTH-1:0]  rsp_root_plus,
   output logic signed [ROOT_WIDTH-1:0]  rsp_root_minus
);

   localparam int W    = COEF_WIDTH;
   localparam int DW   = 2*W+3;
   localparam int NUMW = W+FRAC_BITS+1;
   localparam int DNW  = W+1;
   localparam int JW   = 3+1+NUMW+1+DNW+DW;

   logic            job_valid, job_ready;
   qrs_class_type   job_cls;
   logic            job_num_neg, job_den_neg;
   logic [NUMW-1:0] job_num_mag;
   logic [DNW-1:0]  job_den_mag;
   logic [DW-1:0]   job_disc;
   logic            q_valid, q_pop;
   logic [JW-1:0]   q_word;

   qrs_front #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_coef_a  (req_coef_a),
      .req_coef_b  (req_coef_b),
      .req_coef_c  (req_coef_c),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job_cls     (job_cls),
      .job_num_neg (job_num_neg),
      .job_num_mag (job_num_mag),
      .job_den_neg (job_den_neg),
      .job_den_mag (job_den_mag),
      .job_disc    (job_disc)
   );

   qrs_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid),
      .in_ready  (job_ready),
      .in_data   ({job_cls, job_num_neg, job_num_mag, job_den_neg, job_den_mag, job_disc}),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_data  (q_word)
   );

   qrs_back #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (q_valid),
      .job_pop            (q_pop),
      .job_word           (q_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_solution_class (rsp_solution_class),
      .rsp_root_plus      (rsp_root_plus),
      .rsp_root_minus     (rsp_root_minus)
   );

endmodule

// ===== design/qrs_front.sv =====
module qrs_front import qrs_pkg::*; #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_a,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_b,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_c,
   output logic                          job_valid,
   input  logic                          job_ready,
   output qrs_class_type                 job_cls,
   output logic                          job_num_neg,
   output logic [COEF_WIDTH+FRAC_BITS:0] job_num_mag,
   output logic                          job_den_neg,
   output logic [COEF_WIDTH:0]           job_den_mag,
   output logic [2*COEF_WIDTH+2:0]       job_disc
);

   localparam int W    = COEF_WIDTH;
   localparam int DW   = 2*W+3;
   localparam int NUMW = W+FRAC_BITS+1;
   localparam int DNW  = W+1;

   logic [W:0]     ma, mb, mc;
   logic           v1_ff, v2_ff;
   logic           na_ff, nb_ff, nc_ff;
   logic [W:0]     ma_ff, mb_ff, mc_ff;
   logic [2*W+1:0] bsq_ff, ac_ff;
   logic           rdy1, rdy2;

   logic [DW-1:0]  bsq_e, fac_e, disc;
   logic           ac_pos, dneg;
   qrs_class_type  cls_in;
   logic           num_neg_in, den_neg_in;
   logic [NUMW-1:0] num_mag_in;
   logic [DNW-1:0] den_mag_in;

   qrs_class_type  cls_ff;
   logic           num_neg_ff, den_neg_ff;
   logic [NUMW-1:0] num_mag_ff;
   logic [DNW-1:0] den_mag_ff;
   logic [DW-1:0]  disc_ff;

   assign rdy2      = !v2_ff || job_ready;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   // magnitudes keep one extra bit so the most negative value survives
   assign ma = req_coef_a[W-1] ? (W+1)'(~{1'b1, req_coef_a} + 1'b1) : {1'b0, req_coef_a};
   assign mb = req_coef_b[W-1] ? (W+1)'(~{1'b1, req_coef_b} + 1'b1) : {1'b0, req_coef_b};
   assign mc = req_coef_c[W-1] ? (W+1)'(~{1'b1, req_coef_c} + 1'b1) : {1'b0, req_coef_c};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_valid;
      end
      if (rdy1 && req_valid) begin
         na_ff  <= req_coef_a[W-1];
         nb_ff  <= req_coef_b[W-1];
         nc_ff  <= req_coef_c[W-1];
         ma_ff  <= ma;
         mb_ff  <= mb;
         mc_ff  <= mc;
         bsq_ff <= mb * mb;
         ac_ff  <= ma * mc;
      end
   end

   always_comb begin
      bsq_e      = DW'(bsq_ff);
      fac_e      = DW'(ac_ff) << 2;
      ac_pos     = (mc_ff != '0) && (na_ff == nc_ff);
      dneg       = 1'b0;
      disc       = '0;
      if (!ac_pos) begin
         disc = bsq_e + fac_e;
      end else if (bsq_e >= fac_e) begin
         disc = bsq_e - fac_e;
      end else begin
         dneg = 1'b1;
      end
      cls_in     = CLS_INFINITE;
      num_neg_in = 1'b0;
      num_mag_in = '0;
      den_neg_in = 1'b0;
      den_mag_in = '0;
      if (ma_ff == '0) begin
         if (mb_ff == '0) begin
            cls_in = (mc_ff == '0) ? CLS_INFINITE : CLS_NONE;
         end else begin
            cls_in     = CLS_ONE;
            num_neg_in = (mc_ff != '0) && !nc_ff;
            num_mag_in = NUMW'(mc_ff) << FRAC_BITS;
            den_neg_in = nb_ff;
            den_mag_in = DNW'(mb_ff);
         end
      end else if (dneg) begin
         cls_in = CLS_NO_REAL;
      end else begin
         cls_in     = (disc == '0) ? CLS_ONE : CLS_TWO;
         num_neg_in = (mb_ff != '0) && !nb_ff;
         num_mag_in = NUMW'(mb_ff) << FRAC_BITS;
         den_neg_in = na_ff;
         den_mag_in = DNW'({ma_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2 && v1_ff) begin
         cls_ff     <= cls_in;
         num_neg_ff <= num_neg_in;
         num_mag_ff <= num_mag_in;
         den_neg_ff <= den_neg_in;
         den_mag_ff <= den_mag_in;
         disc_ff    <= disc;
      end
   end

   assign job_valid   = v2_ff;
   assign job_cls     = cls_ff;
   assign job_num_neg = num_neg_ff;
   assign job_num_mag = num_mag_ff;
   assign job_den_neg = den_neg_ff;
   assign job_den_mag = den_mag_ff;
   assign job_disc    = disc_ff;

endmodule

// ===== design/qrs_queue.sv =====
module qrs_queue import qrs_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [WIDTH-1:0] out_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH+1);

   logic [WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    count_ff;
   logic             push, pop;

   assign in_ready  = count_ff != CW'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= PW'(wr_ff + 1'b1);
         end
         if (pop) begin
            rd_ff <= PW'(rd_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= CW'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= CW'(count_ff - 1'b1);
         end
      end
   end

endmodule

// ===== design/qrs_sqrt_pipe.sv =====
module qrs_sqrt_pipe import qrs_pkg::*; #(
   parameter int ROOT_W = 34,
   parameter int SB_W   = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] in_rad,
   input  logic [SB_W-1:0]     in_sb,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [SB_W-1:0]     out_sb
);

   localparam int RAD_W = 2*ROOT_W;
   localparam int REM_W = ROOT_W+2;
   localparam int EXT_W = ROOT_W+4;

   logic              valid_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [SB_W-1:0]   sb_ff    [ROOT_W];

   logic              valid_src [ROOT_W];
   logic [RAD_W-1:0]  rad_src   [ROOT_W];
   logic [ROOT_W-1:0] root_src  [ROOT_W];
   logic [REM_W-1:0]  rem_src   [ROOT_W];
   logic [SB_W-1:0]   sb_src    [ROOT_W];
   logic [EXT_W-1:0]  acc       [ROOT_W];
   logic [EXT_W-1:0]  trial     [ROOT_W];
   logic [ROOT_W-1:0] root_in   [ROOT_W];
   logic [REM_W-1:0]  rem_in    [ROOT_W];

   always_comb begin
      valid_src[0] = in_valid;
      rad_src[0]   = in_rad;
      root_src[0]  = '0;
      rem_src[0]   = '0;
      sb_src[0]    = in_sb;
      for (int k = 1; k < ROOT_W; k++) begin
         valid_src[k] = valid_ff[k-1];
         rad_src[k]   = rad_ff[k-1];
         root_src[k]  = root_ff[k-1];
         rem_src[k]   = rem_ff[k-1];
         sb_src[k]    = sb_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         acc[k]   = {rem_src[k], rad_src[k][RAD_W-1 -: 2]};
         trial[k] = {2'b00, root_src[k], 2'b01};
         if (acc[k] >= trial[k]) begin
            rem_in[k]  = REM_W'(acc[k] - trial[k]);
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = acc[k][REM_W-1:0];
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            valid_ff[k] <= valid_src[k];
         end
      end
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rad_ff[k]  <= rad_src[k] << 2;
            root_ff[k] <= root_in[k];
            rem_ff[k]  <= rem_in[k];
            sb_ff[k]   <= sb_src[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_sb    = sb_ff[ROOT_W-1];

endmodule

// ===== design/qrs_div_pipe.sv =====
module qrs_div_pipe import qrs_pkg::*; #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 17,
   parameter int SB_W  = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num_a,
   input  logic [NUM_W-1:0] in_num_b,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo_a,
   output logic [NUM_W-1:0] out_quo_b,
   output logic [SB_W-1:0]  out_sb
);

   logic             valid_ff [NUM_W];
   logic [NUM_W-1:0] na_ff    [NUM_W];
   logic [NUM_W-1:0] nb_ff    [NUM_W];
   logic [NUM_W-1:0] qa_ff    [NUM_W];
   logic [NUM_W-1:0] qb_ff    [NUM_W];
   logic [DEN_W-1:0] ra_ff    [NUM_W];
   logic [DEN_W-1:0] rb_ff    [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   logic [SB_W-1:0]  sb_ff    [NUM_W];

   logic             valid_src [NUM_W];
   logic [NUM_W-1:0] na_src    [NUM_W];
   logic [NUM_W-1:0] nb_src    [NUM_W];
   logic [NUM_W-1:0] qa_src    [NUM_W];
   logic [NUM_W-1:0] qb_src    [NUM_W];
   logic [DEN_W-1:0] ra_src    [NUM_W];
   logic [DEN_W-1:0] rb_src    [NUM_W];
   logic [DEN_W-1:0] den_src   [NUM_W];
   logic [SB_W-1:0]  sb_src    [NUM_W];
   logic [DEN_W:0]   acc_a     [NUM_W];
   logic [DEN_W:0]   acc_b     [NUM_W];
   logic [DEN_W:0]   den_e     [NUM_W];
   logic             bit_a     [NUM_W];
   logic             bit_b     [NUM_W];
   logic [DEN_W-1:0] ra_in     [NUM_W];
   logic [DEN_W-1:0] rb_in     [NUM_W];

   always_comb begin
      valid_src[0] = in_valid;
      na_src[0]    = in_num_a;
      nb_src[0]    = in_num_b;
      qa_src[0]    = '0;
      qb_src[0]    = '0;
      ra_src[0]    = '0;
      rb_src[0]    = '0;
      den_src[0]   = in_den;
      sb_src[0]    = in_sb;
      for (int k = 1; k < NUM_W; k++) begin
         valid_src[k] = valid_ff[k-1];
         na_src[k]    = na_ff[k-1];
         nb_src[k]    = nb_ff[k-1];
         qa_src[k]    = qa_ff[k-1];
         qb_src[k]    = qb_ff[k-1];
         ra_src[k]    = ra_ff[k-1];
         rb_src[k]    = rb_ff[k-1];
         den_src[k]   = den_ff[k-1];
         sb_src[k]    = sb_ff[k-1];
      end
      for (int k = 0; k < NUM_W; k++) begin
         den_e[k] = {1'b0, den_src[k]};
         acc_a[k] = {ra_src[k], na_src[k][NUM_W-1]};
         acc_b[k] = {rb_src[k], nb_src[k][NUM_W-1]};
         bit_a[k] = acc_a[k] >= den_e[k];
         bit_b[k] = acc_b[k] >= den_e[k];
         ra_in[k] = bit_a[k] ? DEN_W'(acc_a[k] - den_e[k]) : acc_a[k][DEN_W-1:0];
         rb_in[k] = bit_b[k] ? DEN_W'(acc_b[k] - den_e[k]) : acc_b[k][DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < NUM_W; k++) begin
            valid_ff[k] <= valid_src[k];
         end
      end
      if (en) begin
         for (int k = 0; k < NUM_W; k++) begin
            na_ff[k]  <= na_src[k] << 1;
            nb_ff[k]  <= nb_src[k] << 1;
            qa_ff[k]  <= {qa_src[k][NUM_W-2:0], bit_a[k]};
            qb_ff[k]  <= {qb_src[k][NUM_W-2:0], bit_b[k]};
            ra_ff[k]  <= ra_in[k];
            rb_ff[k]  <= rb_in[k];
            den_ff[k] <= den_src[k];
            sb_ff[k]  <= sb_src[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo_a = qa_ff[NUM_W-1];
   assign out_quo_b = qb_ff[NUM_W-1];
   assign out_sb    = sb_ff[NUM_W-1];

endmodule

// ===== design/qrs_back.sv =====
module qrs_back import qrs_pkg::*; #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_pop,
   input  logic [4*COEF_WIDTH+FRAC_BITS+9:0] job_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_solution_class,
   output logic signed [ROOT_WIDTH-1:0] rsp_root_plus,
   output logic signed [ROOT_WIDTH-1:0] rsp_root_minus
);

   localparam int W    = COEF_WIDTH;
   localparam int DW   = 2*W+3;
   localparam int NUMW = W+FRAC_BITS+1;
   localparam int DNW  = W+1;
   localparam int JW   = 3+1+NUMW+1+DNW+DW;
   localparam int SW   = (DW+2*FRAC_BITS+1)/2;
   localparam int RADW = 2*SW;
   localparam int SQSB = 3+1+NUMW+1+DNW;
   localparam int DVSB = 5;
   localparam int EW   = (NUMW > ROOT_WIDTH+1) ? NUMW : ROOT_WIDTH+1;
   localparam logic [ROOT_WIDTH-1:0] LIM = ROOT_WIDTH'(1) << (ROOT_WIDTH-1);

   function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [NUMW-1:0] q,
                                                     input logic neg);
      logic [EW-1:0]         qe;
      logic [ROOT_WIDTH-1:0] m;
      qe = EW'(q);
      if (qe > EW'(LIM)) begin
         m = LIM;
      end else begin
         m = qe[ROOT_WIDTH-1:0];
      end
      if (!neg && m >= LIM) begin
         m = LIM - 1'b1;
      end
      return neg ? ROOT_WIDTH'(~m + 1'b1) : m;
   endfunction

   logic            en;
   logic [DW-1:0]   j_disc;
   logic [RADW-1:0] rad;
   logic [SQSB-1:0] sq_sb_in, sq_sb;
   logic            sq_valid;
   logic [SW-1:0]   sq_root;

   qrs_class_type   s_cls;
   logic            s_num_neg, s_den_neg;
   logic [NUMW-1:0] s_num_mag;
   logic [DNW-1:0]  s_den_mag;
   logic [SW:0]     nb, sr, pm, mm;
   logic            pn, mn;

   logic            nm_valid_ff;
   qrs_class_type   nm_cls_ff;
   logic            nm_pneg_ff, nm_mneg_ff;
   logic [NUMW-1:0] nm_plus_ff, nm_minus_ff;
   logic [DNW-1:0]  nm_den_ff;

   logic            dv_valid;
   logic [NUMW-1:0] dv_qa, dv_qb;
   logic [DVSB-1:0] dv_sb;
   qrs_class_type   d_cls;

   logic            out_valid_ff;
   logic [2:0]      cls_ff;
   logic [ROOT_WIDTH-1:0] plus_ff, minus_ff;

   assign en      = !out_valid_ff || !rsp_stall;
   assign job_pop = en && job_valid;

   assign j_disc   = job_word[DW-1:0];
   assign rad      = RADW'(j_disc) << (2*FRAC_BITS);
   assign sq_sb_in = job_word[JW-1:DW];

   qrs_sqrt_pipe #(
      .ROOT_W (SW),
      .SB_W   (SQSB)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (job_valid),
      .in_rad    (rad),
      .in_sb     (sq_sb_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_sb    (sq_sb)
   );

   assign s_den_mag = sq_sb[DNW-1:0];
   assign s_den_neg = sq_sb[DNW];
   assign s_num_mag = sq_sb[DNW+1 +: NUMW];
   assign s_num_neg = sq_sb[DNW+1+NUMW];
   assign s_cls     = qrs_class_type'(sq_sb[SQSB-1 -: 3]);

   always_comb begin
      nb = (SW+1)'(s_num_mag);
      sr = (SW+1)'(sq_root);
      pm = nb;
      pn = s_num_neg;
      mm = '0;
      mn = 1'b0;
      if (s_cls == CLS_TWO) begin
         if (!s_num_neg) begin
            pm = nb + sr;
            pn = 1'b0;
         end else if (nb >= sr) begin
            pm = nb - sr;
            pn = 1'b1;
         end else begin
            pm = sr - nb;
            pn = 1'b0;
         end
         if (s_num_neg) begin
            mm = nb + sr;
            mn = 1'b1;
         end else if (nb >= sr) begin
            mm = nb - sr;
            mn = 1'b0;
         end else begin
            mm = sr - nb;
            mn = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_valid_ff <= 1'b0;
      end else if (en) begin
         nm_valid_ff <= sq_valid;
      end
      if (en) begin
         nm_cls_ff   <= s_cls;
         nm_pneg_ff  <= pn ^ s_den_neg;
         nm_mneg_ff  <= mn ^ s_den_neg;
         nm_plus_ff  <= pm[NUMW-1:0];
         nm_minus_ff <= mm[NUMW-1:0];
         nm_den_ff   <= s_den_mag;
      end
   end

   qrs_div_pipe #(
      .NUM_W (NUMW),
      .DEN_W (DNW),
      .SB_W  (DVSB)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nm_valid_ff),
      .in_num_a  (nm_plus_ff),
      .in_num_b  (nm_minus_ff),
      .in_den    (nm_den_ff),
      .in_sb     ({nm_cls_ff, nm_pneg_ff, nm_mneg_ff}),
      .out_valid (dv_valid),
      .out_quo_a (dv_qa),
      .out_quo_b (dv_qb),
      .out_sb    (dv_sb)
   );

   assign d_cls = qrs_class_type'(dv_sb[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid;
      end
      if (en) begin
         cls_ff   <= d_cls;
         plus_ff  <= (d_cls inside {CLS_ONE, CLS_TWO}) ? sat_root(dv_qa, dv_sb[1]) : '0;
         minus_ff <= (d_cls == CLS_TWO) ? sat_root(dv_qb, dv_sb[0]) : '0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_solution_class = cls_ff;
   assign rsp_root_plus      = plus_ff;
   assign rsp_root_minus     = minus_ff;

endmodule
